/* rtl/pbm_pkg.sv */
// Shared types, constants and register indexes for the periodic burst marker.
package pbm_pkg;

	localparam int DEF_SAMPLE_WIDTH = 16;
	localparam int DEF_COUNT_WIDTH  = 24;
	localparam int NUM_OFFSETS      = 3;
	localparam int CFG_DATA_WIDTH   = 64;
	localparam int CFG_INDEX_WIDTH  = 3;
	localparam int STEP_WIDTH       = 32;
	localparam int TIME_WIDTH       = 64;
	localparam int OCOUNT_WIDTH     = 2;

	localparam longint unsigned RST_PERIOD     = 1000;
	localparam longint unsigned RST_BURST_SIZE = 100;
	localparam logic [OCOUNT_WIDTH-1:0] RST_OFFSET_COUNT = 2'd1;
	localparam logic [TIME_WIDTH-1:0]   RST_TIME_START   = '0;
	localparam logic [STEP_WIDTH-1:0]   RST_TIME_STEP    = 32'd4295;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_PERIOD       = 3'd0,
		REG_BURST_SIZE   = 3'd1,
		REG_OFFSET_COUNT = 3'd2,
		REG_OFFSET_FIRST = 3'd3,
		REG_OFFSET_SECOND = 3'd4,
		REG_OFFSET_THIRD = 3'd5,
		REG_TIME_START   = 3'd6,
		REG_TIME_STEP    = 3'd7
	} cfg_reg_t;

	// Control that the top level hands to the scheduler.
	typedef struct packed {
		logic advance;
		logic rearm;
	} sched_ctrl_t;

endpackage

/* rtl/pbm_cfg_regs.sv */
// Configuration register file with the pending re-arm flag.
module pbm_cfg_regs #(
	parameter int COUNT_WIDTH = pbm_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [pbm_pkg::CFG_INDEX_WIDTH-1:0]     cfg_index,
	input  logic [pbm_pkg::CFG_DATA_WIDTH-1:0]      cfg_data,
	input  logic                                    advance,
	output logic [COUNT_WIDTH-1:0]                  period,
	output logic [COUNT_WIDTH-1:0]                  burst_size,
	output logic [pbm_pkg::OCOUNT_WIDTH-1:0]        offset_count,
	output logic [COUNT_WIDTH-1:0]                  offset [pbm_pkg::NUM_OFFSETS],
	output logic [pbm_pkg::TIME_WIDTH-1:0]          time_start,
	output logic [pbm_pkg::STEP_WIDTH-1:0]          time_step,
	output logic                                    rearm
);
	import pbm_pkg::*;

	logic [COUNT_WIDTH-1:0]  period_q;
	logic [COUNT_WIDTH-1:0]  burst_size_q;
	logic [OCOUNT_WIDTH-1:0] offset_count_q;
	logic [COUNT_WIDTH-1:0]  offset_q [NUM_OFFSETS];
	logic [TIME_WIDTH-1:0]   time_start_q;
	logic [STEP_WIDTH-1:0]   time_step_q;
	logic                    rearm_q;

	// Any write re-arms the schedule; the first sample after it is index zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q       <= COUNT_WIDTH'(RST_PERIOD);
			burst_size_q   <= COUNT_WIDTH'(RST_BURST_SIZE);
			offset_count_q <= RST_OFFSET_COUNT;
			for (int i = 0; i < NUM_OFFSETS; i++) begin
				offset_q[i] <= '0;
			end
			time_start_q   <= RST_TIME_START;
			time_step_q    <= RST_TIME_STEP;
			rearm_q        <= 1'b1;
		end else if (cfg_we) begin
			rearm_q <= 1'b1;
			unique case (cfg_reg_t'(cfg_index))
				REG_PERIOD:        period_q       <= cfg_data[COUNT_WIDTH-1:0];
				REG_BURST_SIZE:    burst_size_q   <= cfg_data[COUNT_WIDTH-1:0];
				REG_OFFSET_COUNT:  offset_count_q <= cfg_data[OCOUNT_WIDTH-1:0];
				REG_OFFSET_FIRST:  offset_q[0]    <= cfg_data[COUNT_WIDTH-1:0];
				REG_OFFSET_SECOND: offset_q[1]    <= cfg_data[COUNT_WIDTH-1:0];
				REG_OFFSET_THIRD:  offset_q[2]    <= cfg_data[COUNT_WIDTH-1:0];
				REG_TIME_START:    time_start_q   <= cfg_data[TIME_WIDTH-1:0];
				REG_TIME_STEP:     time_step_q    <= cfg_data[STEP_WIDTH-1:0];
				default: ;
			endcase
		end else if (advance) begin
			rearm_q <= 1'b0;
		end
	end

	assign period       = period_q;
	assign burst_size   = burst_size_q;
	assign offset_count = offset_count_q;
	assign offset       = offset_q;
	assign time_start   = time_start_q;
	assign time_step    = time_step_q;
	assign rearm        = rearm_q;

endmodule

/* rtl/pbm_sched.sv */
// Burst scheduler: start and end countdowns per offset and the 32.32 time accumulator.
module pbm_sched #(
	parameter int COUNT_WIDTH = pbm_pkg::DEF_COUNT_WIDTH
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  pbm_pkg::sched_ctrl_t               ctrl,
	input  logic [COUNT_WIDTH-1:0]             period,
	input  logic [COUNT_WIDTH-1:0]             burst_size,
	input  logic [pbm_pkg::OCOUNT_WIDTH-1:0]   offset_count,
	input  logic [COUNT_WIDTH-1:0]             offset [pbm_pkg::NUM_OFFSETS],
	input  logic [pbm_pkg::TIME_WIDTH-1:0]     time_start,
	input  logic [pbm_pkg::STEP_WIDTH-1:0]     time_step,
	output logic                               start_hit,
	output logic                               end_hit,
	output logic [pbm_pkg::TIME_WIDTH-1:0]     time_now
);
	import pbm_pkg::*;

	logic [COUNT_WIDTH-1:0]  eff_len;
	logic [COUNT_WIDTH-1:0]  reload;
	logic [OCOUNT_WIDTH-1:0] n_act;
	logic [NUM_OFFSETS-1:0]  start_vec;
	logic [NUM_OFFSETS-1:0]  end_vec;
	logic [TIME_WIDTH-1:0]   accum_q;

	// A zero length means a one-sample burst, a zero period falls back to the length.
	assign eff_len = (burst_size == '0) ? COUNT_WIDTH'(1) : burst_size;
	assign reload  = ((period == '0) ? eff_len : period) - COUNT_WIDTH'(1);
	assign n_act   = (offset_count == '0) ? OCOUNT_WIDTH'(1) : offset_count;

	for (genvar g = 0; g < NUM_OFFSETS; g++) begin : g_off
		localparam logic [OCOUNT_WIDTH-1:0] IDX = OCOUNT_WIDTH'(g);
		logic [COUNT_WIDTH-1:0] start_cnt_q;
		logic [COUNT_WIDTH:0]   end_cnt_q;
		logic [COUNT_WIDTH-1:0] start_cur;
		logic [COUNT_WIDTH:0]   end_cur;
		logic [COUNT_WIDTH-1:0] start_nxt;
		logic [COUNT_WIDTH:0]   end_nxt;
		logic                   active;

		assign active    = (IDX < n_act);
		assign start_cur = ctrl.rearm ? offset[g] : start_cnt_q;
		assign end_cur   = ctrl.rearm
			? ({1'b0, offset[g]} + {1'b0, eff_len} - (COUNT_WIDTH+1)'(1))
			: end_cnt_q;
		assign start_vec[g] = active && (start_cur == '0);
		assign end_vec[g]   = active && (end_cur == '0);

		always_comb begin
			start_nxt = start_cur;
			end_nxt   = end_cur;
			if (active) begin
				start_nxt = start_vec[g] ? reload : start_cur - COUNT_WIDTH'(1);
				end_nxt   = end_vec[g] ? {1'b0, reload} : end_cur - (COUNT_WIDTH+1)'(1);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				start_cnt_q <= '0;
				end_cnt_q   <= '0;
			end else if (ctrl.advance) begin
				start_cnt_q <= start_nxt;
				end_cnt_q   <= end_nxt;
			end
		end
	end

	assign start_hit = |start_vec;
	assign end_hit   = |end_vec;
	assign time_now  = ctrl.rearm ? time_start : accum_q;

	// The accumulator wraps modulo 2^64.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= '0;
		end else if (ctrl.advance) begin
			accum_q <= time_now + {{(TIME_WIDTH-STEP_WIDTH){1'b0}}, time_step};
		end
	end

endmodule

/* rtl/periodic_burst_marker.sv */
// Top level of the periodic burst marker: input stage, scheduler and result register.
//
// Complex samples enter on the input channel (in_valid/in_stall) and leave
// unchanged on the output channel (out_valid/out_stall), one result per
// sample. A transfer takes place at a rising edge with valid high and stall low.
// Each result carries start_mark and end_mark for the burst schedule, and at a
// start the transmit time in whole seconds and a 32-bit fraction; the time
// fields are zero on other samples.
// A sample is held in the input stage and is then loaded into the result
// register. One sample is taken every cycle while the receiver does not
// stall; the countdowns and the accumulator step once per sample inside
// that single pass.
// When the receiver stalls, the result register holds its contents and the
// input stage, if empty, still takes one more sample before in_stall is raised.
// Reset empties both stages and loads the register defaults; the schedule is
// armed so that the first sample after reset, or after any configuration
// write, is sample index zero. Write configuration only while the block is idle.
module periodic_burst_marker #(
	parameter int SAMPLE_WIDTH = pbm_pkg::DEF_SAMPLE_WIDTH,
	parameter int COUNT_WIDTH  = pbm_pkg::DEF_COUNT_WIDTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [pbm_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [pbm_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_re,
	input  logic signed [SAMPLE_WIDTH-1:0]       sample_im,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]       out_re,
	output logic signed [SAMPLE_WIDTH-1:0]       out_im,
	output logic                                 start_mark,
	output logic                                 end_mark,
	output logic [31:0]                          time_seconds,
	output logic [31:0]                          time_fraction
);
	import pbm_pkg::*;

	logic [COUNT_WIDTH-1:0]  period;
	logic [COUNT_WIDTH-1:0]  burst_size;
	logic [OCOUNT_WIDTH-1:0] offset_count;
	logic [COUNT_WIDTH-1:0]  offset [NUM_OFFSETS];
	logic [TIME_WIDTH-1:0]   time_start;
	logic [STEP_WIDTH-1:0]   time_step;
	logic                    rearm;
	sched_ctrl_t             ctrl;
	logic                    start_hit;
	logic                    end_hit;
	logic [TIME_WIDTH-1:0]   time_now;

	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] re_s1;
	logic signed [SAMPLE_WIDTH-1:0] im_s1;
	logic                           valid_s2;
	logic signed [SAMPLE_WIDTH-1:0] re_s2;
	logic signed [SAMPLE_WIDTH-1:0] im_s2;
	logic                           start_s2;
	logic                           end_s2;
	logic [TIME_WIDTH-1:0]          time_s2;
	logic                           advance;

	assign advance      = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall     = valid_s1 && !advance;
	assign ctrl.advance = advance;
	assign ctrl.rearm   = rearm;

	pbm_cfg_regs #(.COUNT_WIDTH(COUNT_WIDTH)) u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.advance      (advance),
		.period       (period),
		.burst_size   (burst_size),
		.offset_count (offset_count),
		.offset       (offset),
		.time_start   (time_start),
		.time_step    (time_step),
		.rearm        (rearm)
	);

	pbm_sched #(.COUNT_WIDTH(COUNT_WIDTH)) u_sched (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctrl         (ctrl),
		.period       (period),
		.burst_size   (burst_size),
		.offset_count (offset_count),
		.offset       (offset),
		.time_start   (time_start),
		.time_step    (time_step),
		.start_hit    (start_hit),
		.end_hit      (end_hit),
		.time_now     (time_now)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			re_s1 <= sample_re;
			im_s1 <= sample_im;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || !out_stall) begin
			valid_s2 <= valid_s1;
		end
	end

	// Time fields are cleared on samples that start no burst.
	always_ff @(posedge clk) begin
		if (advance) begin
			re_s2    <= re_s1;
			im_s2    <= im_s1;
			start_s2 <= start_hit;
			end_s2   <= end_hit;
			time_s2  <= start_hit ? time_now : '0;
		end
	end

	assign out_valid     = valid_s2;
	assign out_re        = re_s2;
	assign out_im        = im_s2;
	assign start_mark    = start_s2;
	assign end_mark      = end_s2;
	assign time_seconds  = time_s2[TIME_WIDTH-1:32];
	assign time_fraction = time_s2[31:0];

endmodule

/* rtl/pbm_checker.sv */
// Port-level checker for the periodic burst marker and its bind statement.
module pbm_checker #(
	parameter int SAMPLE_WIDTH = pbm_pkg::DEF_SAMPLE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_stall,
	input  logic                          out_valid,
	input  logic                          out_stall,
	input  logic signed [SAMPLE_WIDTH-1:0] out_re,
	input  logic signed [SAMPLE_WIDTH-1:0] out_im,
	input  logic                          start_mark,
	input  logic                          end_mark,
	input  logic [31:0]                   time_seconds,
	input  logic [31:0]                   time_fraction
);

	// A stalled result keeps its contents until it is transferred.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_re) && $stable(out_im)
			&& $stable(start_mark) && $stable(end_mark)
			&& $stable(time_seconds) && $stable(time_fraction))
		else $error("stalled result changed");

	// The input side only backs up when the output side is full and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output back-pressure");

	// Time fields are zero on samples that start no burst.
	a_time_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !start_mark |-> time_seconds == 32'd0 && time_fraction == 32'd0)
		else $error("time reported without a start mark");

	// A receiver that takes every result never holds off the sender.
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled although the output was free");

endmodule

bind periodic_burst_marker pbm_checker #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_pbm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.out_re        (out_re),
	.out_im        (out_im),
	.start_mark    (start_mark),
	.end_mark      (end_mark),
	.time_seconds  (time_seconds),
	.time_fraction (time_fraction)
);

/* bench/tb.sv */
// Self-checking testbench for the periodic burst marker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import pbm_pkg::*;

	localparam int SW          = DEF_SAMPLE_WIDTH;
	localparam int CW          = DEF_COUNT_WIDTH;
	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int PRINT_CAP   = 50;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PATTERN
	} stall_mode_t;

	typedef struct packed {
		logic signed [SW-1:0] re;
		logic signed [SW-1:0] im;
		logic                 is_start;
		logic                 is_end;
		logic [31:0]          sec;
		logic [31:0]          frac;
	} marked_sample_t;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_we = 1'b0;
	logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
	logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
	logic                       in_valid = 1'b0;
	logic                       in_stall;
	logic signed [SW-1:0]       sample_re = '0;
	logic signed [SW-1:0]       sample_im = '0;
	logic                       out_valid;
	logic                       out_stall = 1'b0;
	logic signed [SW-1:0]       out_re;
	logic signed [SW-1:0]       out_im;
	logic                       start_mark;
	logic                       end_mark;
	logic [31:0]                time_seconds;
	logic [31:0]                time_fraction;

	// Mirror of the configuration and of the schedule state.
	logic [CW-1:0]         m_period;
	logic [CW-1:0]         m_len;
	logic [1:0]            m_ocount;
	logic [CW-1:0]         m_offset [NUM_OFFSETS];
	logic [TIME_WIDTH-1:0] m_tstart;
	logic [STEP_WIDTH-1:0] m_tstep;
	logic [CW-1:0]         cd_start [NUM_OFFSETS];
	logic [CW:0]           cd_end [NUM_OFFSETS];
	logic [TIME_WIDTH-1:0] time_accum;

	marked_sample_t pending_marks[$];
	int             errors = 0;
	int             cycle_count = 0;
	stall_mode_t    stall_mode = STALL_NONE;
	bit             hold_go = 1'b0;
	bit             hold_seen = 1'b0;
	int             hold_left = 0;

	periodic_burst_marker i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.sample_re     (sample_re),
		.sample_im     (sample_im),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_re        (out_re),
		.out_im        (out_im),
		.start_mark    (start_mark),
		.end_mark      (end_mark),
		.time_seconds  (time_seconds),
		.time_fraction (time_fraction)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic logic [CW-1:0] eff_burst_size();
		return (m_len == 0) ? CW'(1) : m_len;
	endfunction

	// Every register write restarts the schedule at sample index zero.
	function automatic void rearm_schedule();
		for (int i = 0; i < NUM_OFFSETS; i++) begin
			cd_start[i] = m_offset[i];
			cd_end[i] = {1'b0, m_offset[i]} + {1'b0, eff_burst_size()} - (CW+1)'(1);
		end
		time_accum = m_tstart;
	endfunction

	function automatic void reset_marker_model();
		m_period = CW'(RST_PERIOD);
		m_len = CW'(RST_BURST_SIZE);
		m_ocount = RST_OFFSET_COUNT;
		for (int i = 0; i < NUM_OFFSETS; i++)
			m_offset[i] = '0;
		m_tstart = RST_TIME_START;
		m_tstep = RST_TIME_STEP;
		rearm_schedule();
	endfunction

	function automatic void apply_reg_write(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] value);
		case (idx)
			REG_PERIOD:        m_period = value[CW-1:0];
			REG_BURST_SIZE:    m_len = value[CW-1:0];
			REG_OFFSET_COUNT:  m_ocount = value[1:0];
			REG_OFFSET_FIRST:  m_offset[0] = value[CW-1:0];
			REG_OFFSET_SECOND: m_offset[1] = value[CW-1:0];
			REG_OFFSET_THIRD:  m_offset[2] = value[CW-1:0];
			REG_TIME_START:    m_tstart = value[TIME_WIDTH-1:0];
			REG_TIME_STEP:     m_tstep = value[STEP_WIDTH-1:0];
			default:           return;
		endcase
		rearm_schedule();
	endfunction

	// Steps the countdowns and the time accumulator for one sample.
	function automatic marked_sample_t mark_sample(logic signed [SW-1:0] re,
			logic signed [SW-1:0] im);
		marked_sample_t r;
		logic [CW-1:0]  reload;
		int             n_act;
		reload = ((m_period == 0) ? eff_burst_size() : m_period) - CW'(1);
		n_act = (m_ocount == 0) ? 1 : int'(m_ocount);
		r = '0;
		r.re = re;
		r.im = im;
		for (int i = 0; i < n_act; i++) begin
			if (cd_start[i] == 0) begin
				r.is_start = 1'b1;
				cd_start[i] = reload;
			end else begin
				cd_start[i] = cd_start[i] - CW'(1);
			end
			if (cd_end[i] == 0) begin
				r.is_end = 1'b1;
				cd_end[i] = {1'b0, reload};
			end else begin
				cd_end[i] = cd_end[i] - (CW+1)'(1);
			end
		end
		if (r.is_start)
			{r.sec, r.frac} = time_accum;
		time_accum = time_accum + {32'd0, m_tstep};
		return r;
	endfunction

	task automatic report_mismatch(string what);
		errors++;
		if (errors <= PRINT_CAP)
			$display("ERROR cycle %0d: %s", cycle_count, what);
	endtask

	task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	// Every accepted sample yields exactly one expected result.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			pending_marks.insert(pending_marks.size(), mark_sample(sample_re, sample_im));
	end

	always @(posedge clk) begin : result_check
		marked_sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_marks.size() == 0) begin
				report_mismatch("result transfer with no sample outstanding");
			end else begin
				want = pending_marks.pop_front();
				check_field("out_re", 64'(out_re), 64'(want.re));
				check_field("out_im", 64'(out_im), 64'(want.im));
				check_field("start_mark", 64'(start_mark), 64'(want.is_start));
				check_field("end_mark", 64'(end_mark), 64'(want.is_end));
				check_field("time_seconds", 64'(time_seconds), 64'(want.sec));
				check_field("time_fraction", 64'(time_fraction), 64'(want.frac));
			end
		end
	end

	// Receiver back-pressure; a requested hold-off overrides the current pattern.
	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_LIGHT:   out_stall <= ($urandom_range(0, 99) < 25);
				STALL_HEAVY:   out_stall <= ($urandom_range(0, 99) < 70);
				STALL_PATTERN: out_stall <= ((cycle_count % 11) < 3);
				default:       out_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_sample(logic signed [SW-1:0] re, logic signed [SW-1:0] im);
		in_valid <= 1'b1;
		sample_re <= re;
		sample_im <= im;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	task automatic pause_sender(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic stream_samples(int count, bit gapless);
		int burst_left;
		burst_left = $urandom_range(1, 20);
		for (int k = 0; k < count; k++) begin
			send_sample(SW'($urandom()), SW'($urandom()));
			burst_left--;
			if (burst_left == 0) begin
				if (!gapless)
					pause_sender($urandom_range(1, 6));
				burst_left = $urandom_range(1, 24);
			end
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_marks.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Each write is followed by a pause with the enable low so that the enable falls
	// and rises in different steps.
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		apply_reg_write(idx, value);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_schedule(logic [CW-1:0] period, logic [CW-1:0] len,
			logic [1:0] ocount, logic [CW-1:0] off0, logic [CW-1:0] off1,
			logic [CW-1:0] off2, logic [63:0] tstart, logic [31:0] tstep);
		wait_idle();
		write_reg(REG_PERIOD, CFG_DATA_WIDTH'(period));
		write_reg(REG_BURST_SIZE, CFG_DATA_WIDTH'(len));
		write_reg(REG_OFFSET_COUNT, CFG_DATA_WIDTH'(ocount));
		write_reg(REG_OFFSET_FIRST, CFG_DATA_WIDTH'(off0));
		write_reg(REG_OFFSET_SECOND, CFG_DATA_WIDTH'(off1));
		write_reg(REG_OFFSET_THIRD, CFG_DATA_WIDTH'(off2));
		write_reg(REG_TIME_START, tstart);
		write_reg(REG_TIME_STEP, CFG_DATA_WIDTH'(tstep));
	endtask

	task automatic test_extreme_samples();
		logic signed [SW-1:0] corner [12];
		corner = '{16'sh8000, 16'sh7FFF, 16'sh0000, -16'sh0001, 16'sh5555, 16'shAAAA,
			16'sh0001, 16'shFFFE, 16'sh8001, 16'sh7FFE, 16'sh00FF, 16'shFF00};
		stall_mode <= STALL_NONE;
		for (int k = 0; k < 12; k++)
			send_sample(corner[k], corner[11 - k]);
	endtask

	task automatic test_special_cases();
		// Zero period, zero length and zero offset count: every sample both
		// starts and ends a burst, and the accumulator wraps past 2^64.
		write_schedule('0, '0, 2'd0, '0, 24'd5, 24'd7, 64'hFFFF_FFFF_FFFF_F000,
			32'hFFFF_FFFF);
		for (int k = 0; k < 5; k++)
			send_sample(SW'($urandom()), SW'($urandom()));
		// Three offsets, two of them equal, and an end landing on a start.
		write_schedule(24'd6, 24'd3, 2'd3, '0, 24'd2, 24'd2, 64'h0000_0001_8000_0000,
			32'h4000_0000);
		for (int k = 0; k < 8; k++)
			send_sample(SW'($urandom()), SW'($urandom()));
	endtask

	task automatic random_schedule(int kind);
		logic [CW-1:0] period, len, off0, off1, off2;
		logic [1:0]    ocount;
		logic [31:0]   tstep;
		case (kind)
			0: begin
				period = '1;
				len = '1;
				ocount = 2'd3;
				off0 = '0;
				off1 = '1;
				off2 = CW'($urandom_range(0, 3));
			end
			1: begin
				period = CW'($urandom());
				len = CW'($urandom());
				ocount = 2'($urandom());
				off0 = CW'($urandom());
				off1 = CW'($urandom());
				off2 = CW'($urandom());
			end
			2: begin
				period = '0;
				len = CW'($urandom_range(0, 9));
				ocount = 2'd0;
				off0 = CW'($urandom_range(0, 12));
				off1 = CW'($urandom_range(0, 12));
				off2 = CW'($urandom_range(0, 12));
			end
			default: begin
				period = CW'($urandom_range(1, 40));
				len = CW'($urandom_range(1, 50));
				ocount = 2'($urandom_range(0, 3));
				off0 = CW'($urandom_range(0, 60));
				off1 = CW'($urandom_range(0, 60));
				off2 = CW'($urandom_range(0, 60));
			end
		endcase
		case ($urandom_range(0, 5))
			0:       tstep = '0;
			1:       tstep = 32'd1;
			2:       tstep = '1;
			default: tstep = $urandom();
		endcase
		write_schedule(period, len, ocount, off0, off1, off2, {$urandom(), $urandom()}, tstep);
	endtask

	task automatic test_random_schedules();
		for (int p = 0; p < 12; p++) begin
			random_schedule((p < 2) ? p : int'($urandom_range(2, 9)));
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stream_samples(60, $urandom_range(0, 3) == 0);
		end
	endtask

	task automatic test_output_holdoff();
		write_schedule(24'd9, 24'd4, 2'd2, 24'd1, 24'd5, '0, {$urandom(), $urandom()},
			$urandom());
		stall_mode <= STALL_NONE;
		hold_go <= ~hold_go;
		stream_samples(100, 1'b1);
	endtask

	task automatic test_pause_for_drain();
		stall_mode <= STALL_LIGHT;
		stream_samples(50, 1'b0);
		wait_idle();
		stall_mode <= STALL_PATTERN;
		stream_samples(50, 1'b0);
	endtask

	initial begin
		reset_marker_model();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extreme_samples();
		test_special_cases();
		test_random_schedules();
		test_output_holdoff();
		test_pause_for_drain();
		wait_idle();
		repeat (10) @(posedge clk);
		if (pending_marks.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_marks.size()));
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* filelist.f */
rtl/pbm_pkg.sv
rtl/pbm_cfg_regs.sv
rtl/pbm_sched.sv
rtl/periodic_burst_marker.sv
rtl/pbm_checker.sv
bench/tb.sv
